### rtl/aes_ctr_pkg.sv
// ============================================================================
// AES-128 CTR package
// Shared types, S-box and round helpers for the keystream XOR core.
// ============================================================================
package aes_ctr_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumRk     = 44;

  localparam logic [63:0] DefKeyHigh = 64'h2B7E151628AED2A6;
  localparam logic [63:0] DefKeyLow  = 64'hABF7158809CF4F3C;

  typedef enum logic [1:0] {
    RegKeyHigh = 2'd0,
    RegKeyLow  = 2'd1,
    RegNonce   = 2'd2,
    RegStart   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  valid_bytes;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_bytes;
  } out_item_t;

  // What travels down the chain of round cells alongside the state.
  typedef struct packed {
    logic         vld;
    logic [127:0] data;
    logic [4:0]   nbytes;
  } side_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // State byte k (k = 4*column + row) sits in bits 127-8k .. 120-8k.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(c*4+r) -: 8] = sbox(s[127-8*(((c+r)%4)*4+r) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

endpackage

### rtl/aes_ctr_keyexp.sv
// ============================================================================
// AES-128 key expansion
// Iterative expansion, one round key (four words) per cycle, into registers.
// ============================================================================
module aes_ctr_keyexp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [127:0]   key_i,
  output logic           busy_o,
  output logic [1407:0]  rkeys_o
);

  logic [1407:0] rk_q, rk_d;
  logic [3:0]    rnd_q, rnd_d;
  logic [7:0]    rc_q, rc_d;
  logic          busy_q, busy_d;
  logic [127:0]  prev;
  logic [31:0]   w0, w1, w2, w3, tmp;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return aes_ctr_pkg::xtime(x);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return aes_ctr_pkg::sub_word(w);
  endfunction

  always_comb begin
    prev = rk_q[1407 - 128*rnd_q -: 128];
    tmp  = sub_word({prev[23:0], prev[31:24]}) ^ {rc_q, 24'h0};
    w0   = prev[127:96] ^ tmp;
    w1   = prev[95:64] ^ w0;
    w2   = prev[63:32] ^ w1;
    w3   = prev[31:0] ^ w2;
    rk_d   = rk_q;
    rnd_d  = rnd_q;
    rc_d   = rc_q;
    busy_d = busy_q;
    if (start_i) begin
      rk_d[1407 -: 128] = key_i;
      rnd_d  = 4'd0;
      rc_d   = 8'h01;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rk_d[1407 - 128*(rnd_q + 4'd1) -: 128] = {w0, w1, w2, w3};
      rnd_d = rnd_q + 4'd1;
      rc_d  = xtime(rc_q);
      if (rnd_q == 4'(aes_ctr_pkg::NumRounds - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= 4'd0;
      rc_q   <= 8'h01;
      busy_q <= 1'b1;
      rk_q   <= {aes_ctr_pkg::DefKeyHigh, aes_ctr_pkg::DefKeyLow, 1280'h0};
    end else begin
      rnd_q  <= rnd_d;
      rc_q   <= rc_d;
      busy_q <= busy_d;
      rk_q   <= rk_d;
    end
  end

  assign busy_o  = busy_q;
  assign rkeys_o = rk_q;

`ifndef SYNTHESIS
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q <= 4'(aes_ctr_pkg::NumRounds))
    else $error("round key index past last round");
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && rnd_q == 4'(aes_ctr_pkg::NumRounds - 1)) |=> !busy_q)
    else $error("expansion did not finish after last round");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (busy_q && rnd_q == 4'd0))
    else $error("expansion not restarted");
`endif

endmodule

### rtl/aes_ctr_round_cell.sv
// ============================================================================
// AES round cell
// One AES round on the state it receives, registering the result for the next cell.
// ============================================================================
module aes_ctr_round_cell #(
  parameter bit LastRound = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [127:0]        state_i,
  input  aes_ctr_pkg::side_t  side_i,
  input  logic [127:0]        rkey_i,
  output logic [127:0]        state_o,
  output aes_ctr_pkg::side_t  side_o
);

  logic [127:0] state_q, state_d, ss;
  logic         vld_q;
  logic [127:0] data_q;
  logic [4:0]   nb_q;

  always_comb begin
    ss = aes_ctr_pkg::sub_shift(state_i);
    if (LastRound) state_d = ss ^ rkey_i;
    else           state_d = aes_ctr_pkg::mix(ss) ^ rkey_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= side_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      state_q <= state_d;
      data_q  <= side_i.data;
      nb_q    <= side_i.nbytes;
    end
  end

  assign state_o = state_q;
  assign side_o  = '{vld: vld_q, data: data_q, nbytes: nb_q};

endmodule

### rtl/aes128_ctr_keystream_xor_core.sv
// ============================================================================
// AES-128 CTR keystream XOR core
// Counter block encryption through a chain of ten round cells, XOR into data.
// ============================================================================
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | in_item_i
//  out     | output    | out_valid_o / out_stall_i | out_item_o
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// An item passes the input register, ten round cells and the output register,
// one item per cycle sustained while no stall or key expansion holds it. The
// chain moves while the output register is empty or being taken. After reset,
// and after each key write, the key expansion runs, and while it runs no item
// is accepted.
module aes128_ctr_keystream_xor_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  aes_ctr_pkg::in_item_t   in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output aes_ctr_pkg::out_item_t  out_item_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [63:0]             cfg_data_i
);

  localparam int unsigned NR = aes_ctr_pkg::NumRounds;

  logic [63:0] key_hi_q, key_lo_q, nonce_q;
  logic [31:0] start_q, ctr_q, ctr_use;
  logic        kx_start, kx_busy;
  logic [1407:0] rkeys;
  logic        adv, in_acc, out_vld_q;
  logic [4:0]  nb_sat;
  aes_ctr_pkg::out_item_t out_q;

  logic [127:0]       st  [NR+1];
  aes_ctr_pkg::side_t sd  [NR+1];

  assign kx_start = cfg_we_i && (cfg_idx_i == aes_ctr_pkg::RegKeyHigh ||
                                 cfg_idx_i == aes_ctr_pkg::RegKeyLow);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= aes_ctr_pkg::DefKeyHigh;
      key_lo_q <= aes_ctr_pkg::DefKeyLow;
      nonce_q  <= 64'h0;
      start_q  <= 32'h0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aes_ctr_pkg::RegKeyHigh: key_hi_q <= cfg_data_i;
        aes_ctr_pkg::RegKeyLow:  key_lo_q <= cfg_data_i;
        aes_ctr_pkg::RegNonce:   nonce_q  <= cfg_data_i;
        aes_ctr_pkg::RegStart:   start_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  aes_ctr_keyexp u_keyexp (
    .clk_i, .rst_ni,
    .start_i (kx_start),
    .key_i   ({cfg_idx_i == aes_ctr_pkg::RegKeyHigh ? cfg_data_i : key_hi_q,
               cfg_idx_i == aes_ctr_pkg::RegKeyLow  ? cfg_data_i : key_lo_q}),
    .busy_o  (kx_busy),
    .rkeys_o (rkeys)
  );

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv || kx_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ctr_use    = in_item_i.restart ? start_q : ctr_q;
  assign nb_sat     = (in_item_i.valid_bytes > 5'd16) ? 5'd16 : in_item_i.valid_bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= 32'h0;
    end else if (in_acc) begin
      ctr_q <= ctr_use + 32'd1;
    end
  end

  // Input register: counter block with round key 0 already added.
  logic [127:0] st0_q;
  logic         v0_q;
  logic [127:0] d0_q;
  logic [4:0]   n0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st0_q <= {nonce_q, ctr_use, 32'h0} ^ rkeys[1407 -: 128];
      d0_q  <= {in_item_i.data_high, in_item_i.data_low};
      n0_q  <= nb_sat;
    end
  end

  assign st[0] = st0_q;
  assign sd[0] = '{vld: v0_q, data: d0_q, nbytes: n0_q};

  for (genvar g = 0; g < NR; g++) begin : g_cell
    aes_ctr_round_cell #(.LastRound(g == NR - 1)) u_cell (
      .clk_i, .rst_ni,
      .adv_i   (adv),
      .state_i (st[g]),
      .side_i  (sd[g]),
      .rkey_i  (rkeys[1407 - 128*(g+1) -: 128]),
      .state_o (st[g+1]),
      .side_o  (sd[g+1])
    );
  end

  logic [127:0] mask, res;
  always_comb begin
    for (int b = 0; b < 16; b++) begin
      mask[127-8*b -: 8] = (5'(b) < sd[NR].nbytes) ? 8'hff : 8'h00;
    end
    res = (sd[NR].data ^ st[NR]) & mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= sd[NR].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= '{result_high: res[127:64], result_low: res[63:0],
                 result_bytes: sd[NR].nbytes};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled result changed");
  a_no_acc_kx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kx_busy |-> !in_acc)
    else $error("item taken during key expansion");
  a_ctr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_item_i.restart) |=> ctr_q == $past(ctr_q) + 32'd1)
    else $error("counter did not advance");
  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.result_bytes <= 5'd16)
    else $error("byte count above sixteen");
`endif

endmodule
